// ===== hdl/rtt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rtt_pkg;

    localparam int ATOM_W   = 8;
    localparam int CATION_W = 10;
    localparam int TIME_W   = 16;
    localparam int ERR_W    = 2;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ORDER = 2'd2;

    typedef struct packed {
        logic                func;
        logic [ATOM_W-1:0]   atom;
        logic                has_cation;
        logic [CATION_W-1:0] cation;
        logic                list_end;
    } item_t;

    typedef struct packed {
        logic              has_time;
        logic [TIME_W-1:0] residence_time;
        logic [ERR_W-1:0]  error;
        logic              last;
    } result_t;

    typedef enum logic [1:0] {
        CLS_ELEM,
        CLS_FLUSH,
        CLS_SKIP
    } cls_t;

    typedef struct packed {
        cls_t  cls;
        item_t item;
    } entry_t;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_stat_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ATOM_RD,
        ST_ATOM_LD,
        ST_PREV_RD,
        ST_PREV_CHK,
        ST_LIST_RD,
        ST_LIST_CMP,
        ST_SRCH,
        ST_SCMP,
        ST_POST,
        ST_LE,
        ST_END,
        ST_FLUSH,
        ST_FLUSH_EM,
        ST_STATUS
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/rtt_item_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rtt_item_if;
    logic            valid;
    logic            ready;
    rtt_pkg::item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rtt_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rtt_result_if;
    logic             valid;
    logic             ready;
    rtt_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/residence_time_tracker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                         Role
// item     in   func, atom, has_cation, cation, list_end        list element / flush
// result   out  has_time, residence_time, error, last           times, then one status
//
// An element item reads its atom row, is checked against the previous element when
// the current list has one, visits last-list entries and searches the slots for each;
// a flush walks the slots and emits one time per open slot. An out-of-range atom goes
// straight to its status. The back end waits while the result register is full.
// After reset a clearing pass over all NUM_ATOMS atom rows runs; item.ready stays low.
// A two-entry queue takes items while the back end works or result stalls.

module residence_time_tracker_unit #(
    parameter int NUM_ATOMS   = 256,
    parameter int MAX_CATIONS = 16,
    parameter int CATION_BITS = 10,
    parameter int TIME_BITS   = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    rtt_item_if.sink     item,
    rtt_result_if.source result
);

    rtt_pkg::back_stat_t stat;
    logic                q_valid;
    rtt_pkg::entry_t     q_entry;

    rtt_front #(
        .NUM_ATOMS (NUM_ATOMS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .stat    (stat),
        .q_valid (q_valid),
        .q_entry (q_entry)
    );

    rtt_back #(
        .NUM_ATOMS   (NUM_ATOMS),
        .MAX_CATIONS (MAX_CATIONS),
        .CATION_BITS (CATION_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .stat    (stat),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== hdl/rtt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtt_front #(
    parameter int NUM_ATOMS = 256
) (
    input  wire                 clk,
    input  wire                 rst_n,
    rtt_item_if.sink            item,
    input  rtt_pkg::back_stat_t stat,
    output logic                q_valid,
    output rtt_pkg::entry_t     q_entry
);

    rtt_pkg::entry_t fifo_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    rtt_pkg::entry_t new_entry;
    logic            push;
    logic            pop;

    always_comb
    begin
        new_entry.item = item.data;
        if (int'(item.data.atom) >= NUM_ATOMS)
            new_entry.cls = rtt_pkg::CLS_SKIP;
        else if (item.data.func)
            new_entry.cls = rtt_pkg::CLS_FLUSH;
        else
            new_entry.cls = rtt_pkg::CLS_ELEM;
    end

    assign item.ready = (cnt_reg != 2'd2) && !stat.init_busy;
    assign push       = item.valid && item.ready;
    assign pop        = stat.pop && (cnt_reg != 2'd0);
    assign q_valid    = (cnt_reg != 2'd0);
    assign q_entry    = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= new_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rtt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtt_back #(
    parameter int NUM_ATOMS   = 256,
    parameter int MAX_CATIONS = 16,
    parameter int CATION_BITS = 10,
    parameter int TIME_BITS   = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  q_valid,
    input  rtt_pkg::entry_t      q_entry,
    output rtt_pkg::back_stat_t  stat,
    rtt_result_if.source         result
);

    localparam int AAW    = (NUM_ATOMS > 1) ? $clog2(NUM_ATOMS) : 1;
    localparam int PW     = $clog2(MAX_CATIONS + 1);
    localparam int KW     = (MAX_CATIONS > 1) ? $clog2(MAX_CATIONS) : 1;
    localparam int LDEPTH = 2 * NUM_ATOMS * MAX_CATIONS;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int SDEPTH = NUM_ATOMS * MAX_CATIONS;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

    typedef struct packed {
        logic                   bank;
        logic [PW-1:0]          lcnt;
        logic [PW-1:0]          ncnt;
        logic [MAX_CATIONS-1:0] vld;
    } row_t;

    typedef struct packed {
        logic [CATION_BITS-1:0] cat;
        logic [TIME_BITS-1:0]   tm;
    } slot_t;

    row_t                   atom_mem [NUM_ATOMS];
    logic [CATION_BITS-1:0] list_mem [LDEPTH];
    slot_t                  slot_mem [SDEPTH];

    rtt_pkg::state_t        state_reg, state_next;
    rtt_pkg::entry_t        ent_reg, ent_next;
    logic                   bank_reg, bank_next;
    logic [PW-1:0]          lc_reg, lc_next;
    logic [PW-1:0]          nc_reg, nc_next;
    logic [MAX_CATIONS-1:0] vld_reg, vld_next;
    logic [PW-1:0]          ptr_reg, ptr_next;
    logic [PW-1:0]          k_reg, k_next;
    logic [CATION_BITS-1:0] tgt_reg, tgt_next;
    logic                   drain_reg, drain_next;
    logic                   inc_reg, inc_next;
    logic                   isnew_reg, isnew_next;
    logic [rtt_pkg::ERR_W-1:0] err_reg, err_next;
    logic                   ov_reg, ov_next;
    rtt_pkg::result_t       ores_reg, ores_next;
    logic [AAW-1:0]         init_reg, init_next;

    row_t                   row_rd_reg;
    logic [CATION_BITS-1:0] cat_rd_reg;
    slot_t                  slot_rd_reg;

    logic                   row_we, row_re;
    logic [AAW-1:0]         row_wa;
    row_t                   row_wd;
    logic                   list_we, list_re;
    logic [LAW-1:0]         list_wa, list_ra;
    logic                   slot_we, slot_re;
    logic [SAW-1:0]         slot_wa, slot_ra;
    slot_t                  slot_wd;

    logic [AAW-1:0]         atom_idx;
    logic [CATION_BITS-1:0] cat_in;
    logic                   can_emit;
    logic                   k_done;
    logic                   k_vld;
    logic                   ptr_lt;
    logic                   slot_hit;
    logic                   free_found;
    logic [KW-1:0]          free_idx;
    logic [LAW-1:0]         last_base;
    logic [LAW-1:0]         next_base;
    logic [SAW-1:0]         slot_base;
    logic [TIME_BITS-1:0]   tm_inc;
    logic [rtt_pkg::TIME_W-1:0] tm_out;

    assign atom_idx  = AAW'(ent_reg.item.atom);
    assign cat_in    = CATION_BITS'(ent_reg.item.cation);
    assign can_emit  = !ov_reg || result.ready;
    assign k_done    = (k_reg == PW'(MAX_CATIONS));
    assign k_vld     = vld_reg[k_reg[KW-1:0]];
    assign ptr_lt    = (ptr_reg < lc_reg);
    assign slot_hit  = (slot_rd_reg.cat == tgt_reg);
    assign last_base = LAW'(LAW'({atom_idx, bank_reg}) * LAW'(MAX_CATIONS));
    assign next_base = LAW'(LAW'({atom_idx, !bank_reg}) * LAW'(MAX_CATIONS));
    assign slot_base = SAW'(SAW'(atom_idx) * SAW'(MAX_CATIONS));
    assign tm_inc    = (slot_rd_reg.tm == {TIME_BITS{1'b1}}) ? slot_rd_reg.tm
                                                             : slot_rd_reg.tm + 1'b1;

    // saturate to port width
    always_comb
    begin
        if (TIME_BITS > rtt_pkg::TIME_W
            && slot_rd_reg.tm > TIME_BITS'({rtt_pkg::TIME_W{1'b1}}))
            tm_out = {rtt_pkg::TIME_W{1'b1}};
        else
            tm_out = rtt_pkg::TIME_W'(slot_rd_reg.tm);
    end

    // first free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_CATIONS - 1; i >= 0; i--)
        begin
            if (!vld_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = KW'(i);
            end
        end
    end

    assign stat.init_busy = (state_reg == rtt_pkg::ST_INIT);
    assign stat.pop       = (state_reg == rtt_pkg::ST_IDLE) && q_valid;
    assign result.valid   = ov_reg;
    assign result.data    = ores_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtt_pkg::ST_INIT:
                if (init_reg == AAW'(NUM_ATOMS - 1))
                    state_next = rtt_pkg::ST_IDLE;
            rtt_pkg::ST_IDLE:
                if (q_valid)
                    state_next = (q_entry.cls == rtt_pkg::CLS_SKIP) ? rtt_pkg::ST_STATUS
                                                                    : rtt_pkg::ST_ATOM_RD;
            rtt_pkg::ST_ATOM_RD:
                state_next = rtt_pkg::ST_ATOM_LD;
            rtt_pkg::ST_ATOM_LD:
                if (ent_reg.cls == rtt_pkg::CLS_FLUSH)
                    state_next = rtt_pkg::ST_FLUSH;
                else if (!ent_reg.item.has_cation)
                    state_next = rtt_pkg::ST_LE;
                else if (row_rd_reg.ncnt != '0)
                    state_next = rtt_pkg::ST_PREV_RD;
                else
                    state_next = rtt_pkg::ST_LIST_RD;
            rtt_pkg::ST_PREV_RD:
                state_next = rtt_pkg::ST_PREV_CHK;
            rtt_pkg::ST_PREV_CHK:
                state_next = (cat_in <= cat_rd_reg) ? rtt_pkg::ST_LE : rtt_pkg::ST_LIST_RD;
            rtt_pkg::ST_LIST_RD:
                if (ptr_lt)
                    state_next = rtt_pkg::ST_LIST_CMP;
                else
                    state_next = drain_reg ? rtt_pkg::ST_END : rtt_pkg::ST_POST;
            rtt_pkg::ST_LIST_CMP:
                if (drain_reg || cat_rd_reg <= cat_in)
                    state_next = rtt_pkg::ST_SRCH;
                else
                    state_next = rtt_pkg::ST_POST;
            rtt_pkg::ST_SRCH:
                if (k_done)
                    state_next = inc_reg ? rtt_pkg::ST_POST : rtt_pkg::ST_LIST_RD;
                else if (k_vld)
                    state_next = rtt_pkg::ST_SCMP;
            rtt_pkg::ST_SCMP:
                if (!slot_hit)
                    state_next = rtt_pkg::ST_SRCH;
                else if (inc_reg)
                    state_next = rtt_pkg::ST_POST;
                else if (can_emit)
                    state_next = rtt_pkg::ST_LIST_RD;
            rtt_pkg::ST_POST:
                state_next = rtt_pkg::ST_LE;
            rtt_pkg::ST_LE:
                state_next = ent_reg.item.list_end ? rtt_pkg::ST_LIST_RD : rtt_pkg::ST_END;
            rtt_pkg::ST_END:
                state_next = rtt_pkg::ST_STATUS;
            rtt_pkg::ST_FLUSH:
                if (k_done)
                    state_next = rtt_pkg::ST_STATUS;
                else if (k_vld)
                    state_next = rtt_pkg::ST_FLUSH_EM;
            rtt_pkg::ST_FLUSH_EM:
                if (can_emit)
                    state_next = rtt_pkg::ST_FLUSH;
            rtt_pkg::ST_STATUS:
                if (can_emit)
                    state_next = rtt_pkg::ST_IDLE;
            default:
                state_next = rtt_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        ent_next   = ent_reg;
        bank_next  = bank_reg;
        lc_next    = lc_reg;
        nc_next    = nc_reg;
        vld_next   = vld_reg;
        ptr_next   = ptr_reg;
        k_next     = k_reg;
        tgt_next   = tgt_reg;
        drain_next = drain_reg;
        inc_next   = inc_reg;
        isnew_next = isnew_reg;
        err_next   = err_reg;
        init_next  = init_reg;
        ov_next    = ov_reg && !result.ready;
        ores_next  = ores_reg;

        row_we  = 1'b0;
        row_re  = 1'b0;
        row_wa  = atom_idx;
        row_wd  = '0;
        list_we = 1'b0;
        list_re = 1'b0;
        list_wa = next_base + LAW'(nc_reg);
        list_ra = last_base + LAW'(ptr_reg);
        slot_we = 1'b0;
        slot_re = 1'b0;
        slot_wa = slot_base + SAW'(k_reg[KW-1:0]);
        slot_ra = slot_base + SAW'(k_reg[KW-1:0]);
        slot_wd = '0;

        unique case (state_reg)
            rtt_pkg::ST_INIT:
            begin
                row_we    = 1'b1;
                row_wa    = init_reg;
                init_next = init_reg + 1'b1;
            end
            rtt_pkg::ST_IDLE:
                if (q_valid)
                begin
                    ent_next = q_entry;
                    err_next = rtt_pkg::ERR_OK;
                end
            rtt_pkg::ST_ATOM_RD:
                row_re = 1'b1;
            rtt_pkg::ST_ATOM_LD:
            begin
                bank_next  = row_rd_reg.bank;
                lc_next    = row_rd_reg.lcnt;
                nc_next    = row_rd_reg.ncnt;
                vld_next   = row_rd_reg.vld;
                k_next     = '0;
                drain_next = 1'b0;
                isnew_next = 1'b1;
            end
            rtt_pkg::ST_PREV_RD:
            begin
                list_re = 1'b1;
                list_ra = next_base + LAW'(nc_reg - 1'b1);
            end
            rtt_pkg::ST_PREV_CHK:
                if (cat_in <= cat_rd_reg)
                    err_next = rtt_pkg::ERR_ORDER;
            rtt_pkg::ST_LIST_RD:
                list_re = ptr_lt;
            rtt_pkg::ST_LIST_CMP:
                if (drain_reg || cat_rd_reg <= cat_in)
                begin
                    tgt_next = cat_rd_reg;
                    inc_next = !drain_reg && (cat_rd_reg == cat_in);
                    ptr_next = ptr_reg + 1'b1;
                    k_next   = '0;
                end
            rtt_pkg::ST_SRCH:
                if (!k_done)
                begin
                    if (k_vld)
                        slot_re = 1'b1;
                    else
                        k_next = k_reg + 1'b1;
                end
            rtt_pkg::ST_SCMP:
                if (!slot_hit)
                    k_next = k_reg + 1'b1;
                else if (inc_reg)
                begin
                    slot_we    = 1'b1;
                    slot_wd    = '{cat: tgt_reg, tm: tm_inc};
                    isnew_next = 1'b0;
                end
                else if (can_emit)
                begin
                    ov_next   = 1'b1;
                    ores_next = '{has_time: 1'b1, residence_time: tm_out,
                                  error: rtt_pkg::ERR_OK, last: 1'b0};
                    vld_next[k_reg[KW-1:0]] = 1'b0;
                end
            rtt_pkg::ST_POST:
                if (nc_reg >= PW'(MAX_CATIONS))
                    err_next = rtt_pkg::ERR_FULL;
                else if (isnew_reg && !free_found)
                    err_next = rtt_pkg::ERR_FULL;
                else
                begin
                    if (isnew_reg)
                    begin
                        slot_we            = 1'b1;
                        slot_wa            = slot_base + SAW'(free_idx);
                        slot_wd            = '{cat: cat_in, tm: TIME_BITS'(1)};
                        vld_next[free_idx] = 1'b1;
                    end
                    list_we = 1'b1;
                    nc_next = nc_reg + 1'b1;
                end
            rtt_pkg::ST_LE:
                drain_next = ent_reg.item.list_end;
            rtt_pkg::ST_END:
            begin
                row_we = 1'b1;
                if (drain_reg)
                begin
                    row_wd   = '{bank: !bank_reg, lcnt: nc_reg, ncnt: '0, vld: vld_reg};
                    ptr_next = '0;
                end
                else
                    row_wd = '{bank: bank_reg, lcnt: lc_reg, ncnt: nc_reg, vld: vld_reg};
            end
            rtt_pkg::ST_FLUSH:
                if (!k_done)
                begin
                    if (k_vld)
                        slot_re = 1'b1;
                    else
                        k_next = k_reg + 1'b1;
                end
            rtt_pkg::ST_FLUSH_EM:
                if (can_emit)
                begin
                    ov_next   = 1'b1;
                    ores_next = '{has_time: 1'b1, residence_time: tm_out,
                                  error: rtt_pkg::ERR_OK, last: 1'b0};
                    k_next    = k_reg + 1'b1;
                end
            rtt_pkg::ST_STATUS:
                if (can_emit)
                begin
                    ov_next   = 1'b1;
                    ores_next = '{has_time: 1'b0, residence_time: '0,
                                  error: err_reg, last: 1'b1};
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            atom_mem[row_wa] <= row_wd;
        if (row_re)
            row_rd_reg <= atom_mem[atom_idx];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[list_wa] <= cat_in;
        if (list_re)
            cat_rd_reg <= list_mem[list_ra];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_wa] <= slot_wd;
        if (slot_re)
            slot_rd_reg <= slot_mem[slot_ra];
    end

    always_ff @(posedge clk)
    begin
        ent_reg   <= ent_next;
        bank_reg  <= bank_next;
        lc_reg    <= lc_next;
        nc_reg    <= nc_next;
        vld_reg   <= vld_next;
        k_reg     <= k_next;
        tgt_reg   <= tgt_next;
        inc_reg   <= inc_next;
        isnew_reg <= isnew_next;
        err_reg   <= err_next;
        ores_reg  <= ores_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtt_pkg::ST_INIT;
            ptr_reg   <= '0;
            drain_reg <= 1'b0;
            ov_reg    <= 1'b0;
            init_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            drain_reg <= drain_next;
            ov_reg    <= ov_next;
            init_reg  <= init_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/residence_time_tracker_unit_test.sv =====
`timescale 1ns / 1ps

module residence_time_tracker_unit_test;

    localparam int ATOMS = 256;
    localparam int MAXC = 16;
    localparam int TMAX = 65535;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rtt_item_if   item_ch ();
    rtt_result_if result_ch ();

    residence_time_tracker_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // tracker state
    int unsigned prev_list [ATOMS][MAXC];
    int unsigned prev_cnt [ATOMS];
    int unsigned cur_list [ATOMS][MAXC];
    int unsigned cur_cnt [ATOMS];
    int unsigned merge_pos;
    bit          slot_used [ATOMS][MAXC];
    int unsigned slot_cat [ATOMS][MAXC];
    int unsigned slot_tm [ATOMS][MAXC];

    rtt_pkg::result_t expected_results [$];
    int      errors = 0;
    int      results_seen = 0;
    int      items_sent = 0;
    int      cycles = 0;

    int src_idle_pct = 28;
    int snk_idle_pct = 68;
    int hold_off = 0;

    function automatic void push_time(int unsigned t);
        rtt_pkg::result_t r;
        r.has_time = 1'b1;
        r.residence_time = 16'(t);
        r.error = rtt_pkg::ERR_OK;
        r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic int find_slot(int a, int unsigned c);
        for (int k = 0; k < MAXC; k++)
            if (slot_used[a][k] && slot_cat[a][k] == c)
                return k;
        return -1;
    endfunction

    function automatic void end_residence(int a, int unsigned c);
        int s;
        s = find_slot(a, c);
        if (s >= 0)
        begin
            push_time(slot_tm[a][s]);
            slot_used[a][s] = 1'b0;
            slot_tm[a][s] = 0;
        end
    endfunction

    function automatic void predict_residence(rtt_pkg::item_t it);
        int a, s, fs;
        int unsigned ptr, lc, nc, c;
        logic [rtt_pkg::ERR_W-1:0] err;
        bit is_new;
        rtt_pkg::result_t st;
        a = it.atom;
        c = it.cation;
        err = rtt_pkg::ERR_OK;
        if (it.func)
        begin
            for (int k = 0; k < MAXC; k++)
                if (slot_used[a][k])
                    push_time(slot_tm[a][k]);
        end
        else
        begin
            ptr = merge_pos;
            lc = prev_cnt[a];
            if (it.has_cation)
            begin
                nc = cur_cnt[a];
                if (nc > 0 && c <= cur_list[a][nc-1])
                    err = rtt_pkg::ERR_ORDER;
                else
                begin
                    is_new = 1'b1;
                    while (ptr < lc && prev_list[a][ptr] < c)
                    begin
                        end_residence(a, prev_list[a][ptr]);
                        ptr++;
                    end
                    if (ptr < lc && prev_list[a][ptr] == c)
                    begin
                        ptr++;
                        s = find_slot(a, c);
                        if (s >= 0)
                        begin
                            if (slot_tm[a][s] < TMAX)
                                slot_tm[a][s]++;
                            is_new = 1'b0;
                        end
                    end
                    if (nc >= MAXC)
                        err = rtt_pkg::ERR_FULL;
                    else if (is_new)
                    begin
                        fs = -1;
                        for (int k = MAXC - 1; k >= 0; k--)
                            if (!slot_used[a][k])
                                fs = k;
                        if (fs < 0)
                            err = rtt_pkg::ERR_FULL;
                        else
                        begin
                            slot_used[a][fs] = 1'b1;
                            slot_cat[a][fs] = c;
                            slot_tm[a][fs] = 1;
                        end
                    end
                    if (err == rtt_pkg::ERR_OK)
                    begin
                        cur_list[a][nc] = c;
                        cur_cnt[a] = nc + 1;
                    end
                end
            end
            if (it.list_end)
            begin
                while (ptr < lc)
                begin
                    end_residence(a, prev_list[a][ptr]);
                    ptr++;
                end
                for (int k = 0; k < MAXC; k++)
                    prev_list[a][k] = cur_list[a][k];
                prev_cnt[a] = cur_cnt[a];
                cur_cnt[a] = 0;
                ptr = 0;
            end
            merge_pos = ptr;
        end
        st.has_time = 1'b0;
        st.residence_time = '0;
        st.error = err;
        st.last = 1'b1;
        expected_results.push_back(st);
    endfunction

    // directed rows; chk = 1 means the status row is typed in and compared too
    typedef struct {
        rtt_pkg::item_t            it;
        bit                        chk;
        logic [rtt_pkg::ERR_W-1:0] err;
    } row_t;

    function automatic rtt_pkg::item_t mk(bit f, int a, bit h, int c, bit le);
        rtt_pkg::item_t it;
        it.func = f;
        it.atom = 8'(a);
        it.has_cation = h;
        it.cation = 10'(c);
        it.list_end = le;
        return it;
    endfunction

    row_t directed [$];

    task automatic send_item(rtt_pkg::item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        predict_residence(it);
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // one list for an atom: ascending random content
    task automatic send_list(int a, int lo, int span);
        int n, c;
        n = $urandom_range(0, 5);
        c = lo;
        if (n == 0)
            send_item(mk(1'b0, a, 1'b0, $urandom_range(0, 1023), 1'b1));
        for (int k = 0; k < n; k++)
        begin
            c = c + $urandom_range(1, span);
            if (c > 1023)
                c = 1023;
            send_item(mk(1'b0, a, 1'b1, c, k == n - 1));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        rtt_pkg::result_t exp_r;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Cycle limit reached after %0d items and %0d results.",
                     items_sent, results_seen);
            $display("Verification failed");
            $finish;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result_ch.data);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (exp_r !== result_ch.data)
                begin
                    $display("%0t: expected %p actual %p", $time, exp_r, result_ch.data);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rtt_pkg::item_t it;
        int a;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        result_ch.ready = 1'b0;
        merge_pos = 0;
        for (int i = 0; i < ATOMS; i++)
        begin
            prev_cnt[i] = 0;
            cur_cnt[i] = 0;
            for (int k = 0; k < MAXC; k++)
            begin
                slot_used[i][k] = 1'b0;
                slot_tm[i][k] = 0;
                slot_cat[i][k] = 0;
                prev_list[i][k] = 0;
                cur_list[i][k] = 0;
            end
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        directed.push_back('{mk(1'b1, 0, 1'b0, 0, 1'b0), 1'b1, rtt_pkg::ERR_OK});
        directed.push_back('{mk(1'b0, 0, 1'b1, 0, 1'b0), 1'b1, rtt_pkg::ERR_OK});
        directed.push_back('{mk(1'b0, 0, 1'b1, 0, 1'b0), 1'b1, rtt_pkg::ERR_ORDER});
        directed.push_back('{mk(1'b0, 0, 1'b1, 1023, 1'b1), 1'b0, rtt_pkg::ERR_OK});
        directed.push_back('{mk(1'b0, 0, 1'b1, 1023, 1'b0), 1'b0, rtt_pkg::ERR_OK});
        directed.push_back('{mk(1'b0, 0, 1'b0, 5, 1'b1), 1'b0, rtt_pkg::ERR_OK});
        directed.push_back('{mk(1'b1, 0, 1'b0, 0, 1'b0), 1'b0, rtt_pkg::ERR_OK});
        directed.push_back('{mk(1'b0, 255, 1'b1, 512, 1'b0), 1'b1, rtt_pkg::ERR_OK});
        directed.push_back('{mk(1'b0, 1, 1'b1, 341, 1'b0), 1'b0, rtt_pkg::ERR_OK});
        directed.push_back('{mk(1'b0, 255, 1'b1, 600, 1'b1), 1'b0, rtt_pkg::ERR_OK});
        directed.push_back('{mk(1'b0, 1, 1'b1, 682, 1'b1), 1'b0, rtt_pkg::ERR_OK});
        directed.push_back('{mk(1'b0, 255, 1'b0, 1023, 1'b0), 1'b1, rtt_pkg::ERR_OK});
        directed.push_back('{mk(1'b1, 255, 1'b1, 1023, 1'b1), 1'b0, rtt_pkg::ERR_OK});
        directed.push_back('{mk(1'b1, 1, 1'b0, 0, 1'b0), 1'b0, rtt_pkg::ERR_OK});

        foreach (directed[i])
        begin
            send_item(directed[i].it);
            if (directed[i].chk && expected_results[expected_results.size()-1].error
                !== directed[i].err)
            begin
                $display("%0t: expected error %0d actual %0d", $time, directed[i].err,
                         expected_results[expected_results.size()-1].error);
                errors++;
            end
        end
        // table full: 17 cations in one list for atom 2
        for (int k = 0; k <= MAXC; k++)
            send_item(mk(1'b0, 2, 1'b1, 10 * k + 1, k == MAXC));
        send_item(mk(1'b1, 2, 1'b0, 0, 1'b0));

        // long receiver hold-off while the sender keeps offering
        hold_off = 300;
        for (int k = 0; k < 6; k++)
            send_item(mk(1'b1, 2, 1'b0, 0, 1'b0));
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 68 : 0;
            snk_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 28 : 0;
            while (items_sent < 36 + 70 * (ph + 1))
            begin
                case ($urandom_range(9))
                    0:
                        send_item(mk(1'b1, $urandom_range(0, 7), 1'($urandom),
                                     $urandom_range(0, 1023), 1'($urandom)));
                    1:
                    begin
                        it = mk(1'b0, $urandom_range(0, 255), 1'($urandom),
                                $urandom_range(0, 1023), 1'($urandom));
                        send_item(it);
                    end
                    2:
                        send_item(mk(1'b0, $urandom_range(0, 7), 1'b1,
                                     $urandom_range(0, 1023), $urandom_range(3) == 0));
                    default:
                    begin
                        a = $urandom_range(0, 7);
                        send_list(a, $urandom_range(0, 30), 12);
                    end
                endcase
            end
        end
        // close any open list, then flush atoms 0 to 7
        for (int i = 0; i < ATOMS; i++)
            if (cur_cnt[i] != 0)
                send_item(mk(1'b0, i, 1'b0, 0, 1'b1));
        for (int i = 0; i < 8; i++)
            send_item(mk(1'b1, i, 1'b0, 0, 1'b0));
        wait_drained();
        repeat (100) @(posedge clk);
        $display("Sent %0d items, checked %0d results against the tracker model.",
                 items_sent, results_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== residence_time_tracker_unit.f =====
hdl/rtt_pkg.sv
hdl/rtt_item_if.sv
hdl/rtt_result_if.sv
hdl/rtt_front.sv
hdl/rtt_back.sv
hdl/residence_time_tracker_unit.sv
tb/sv/residence_time_tracker_unit_test.sv
